@@ design/cfs_pkg.sv @@
// cfs_pkg: shared types and constants for the CSV field splitter.
// Used by the top level, cfs_core and cfs_out_reg; no dependencies.
package cfs_pkg;

  localparam int POS_W = 12;
  localparam int COL_W = 8;
  localparam int ROW_W = 16;

  localparam logic [POS_W-1:0] POS_MAX = {POS_W{1'b1}};
  localparam logic [COL_W-1:0] COL_MAX = {COL_W{1'b1}};
  localparam logic [ROW_W-1:0] ROW_MAX = {ROW_W{1'b1}};

  localparam logic [7:0] BYTE_NUL = 8'h00;
  localparam logic [7:0] BYTE_LF  = 8'h0a;
  localparam logic [7:0] BYTE_CR  = 8'h0d;

  localparam logic [7:0] DELIM_RESET = 8'd44;
  localparam logic [7:0] QUOTE_RESET = 8'd34;

  localparam logic CFG_DELIM = 1'b0;
  localparam logic CFG_QUOTE = 1'b1;

  typedef struct packed {
    logic [ROW_W-1:0] row_number;
    logic [COL_W-1:0] column_number;
    logic [POS_W-1:0] field_start;
    logic [POS_W-1:0] field_length;
    logic             was_quoted;
    logic             last_of_row;
    logic             end_of_data;
  } result_t;

endpackage

@@ design/csv_field_splitter_unit.sv @@
// csv_field_splitter_unit: CSV byte stream to field descriptors, top level.
// Depends on cfs_pkg, cfs_core and cfs_out_reg.
//
//   channel  | signals                         | moves
//   ---------+---------------------------------+------------------------------
//   in       | in_vld, in_stall, in_data_byte  | one text byte per transfer
//   out      | out_vld, out_stall, out_*       | one closed field per transfer
//   cfg      | cfg_we, cfg_index, cfg_wdata    | delimiter / quote byte write
//
// One byte per cycle unless the input stalls: input register, then the
// tokenizer update, then the result register. A field is valid at the output
// once the byte that closes it has passed the input and result registers.
// Synchronous active-low reset clears valids and tokenizer state; delimiter
// returns to ',' and quote to '"'. An output stall holds the result; the input
// stalls only when a field-closing byte meets a full, stalled result register.
module csv_field_splitter_unit (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_vld,
  output logic        in_stall,
  input  logic [7:0]  in_data_byte,
  output logic        out_vld,
  input  logic        out_stall,
  output logic [15:0] out_row_number,
  output logic [7:0]  out_column_number,
  output logic [11:0] out_field_start,
  output logic [11:0] out_field_length,
  output logic        out_was_quoted,
  output logic        out_last_of_row,
  output logic        out_end_of_data,
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [7:0]  cfg_wdata
);

  logic             s1_vld_r, s1_vld_nxt;
  logic [7:0]       s1_data_r;
  logic [7:0]       delim_r, quote_r;
  logic             proc, res_vld, res_free;
  cfs_pkg::result_t res, out_res;

  assign in_stall   = s1_vld_r && !proc;
  assign s1_vld_nxt = (in_vld && !in_stall) || (s1_vld_r && !proc);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
      delim_r  <= cfs_pkg::DELIM_RESET;
      quote_r  <= cfs_pkg::QUOTE_RESET;
    end else begin
      s1_vld_r <= s1_vld_nxt;
      if (cfg_we && (cfg_index == cfs_pkg::CFG_DELIM)) begin
        delim_r <= cfg_wdata;
      end
      if (cfg_we && (cfg_index == cfs_pkg::CFG_QUOTE)) begin
        quote_r <= cfg_wdata;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_vld && !in_stall) begin
      s1_data_r <= in_data_byte;
    end
  end

  cfs_core u_core (
    .clk            (clk),
    .rst_n          (rst_n),
    .byte_vld       (s1_vld_r),
    .byte_data      (s1_data_r),
    .delimiter_char (delim_r),
    .quote_char     (quote_r),
    .res_free       (res_free),
    .proc           (proc),
    .res_vld        (res_vld),
    .res            (res)
  );

  cfs_out_reg u_out (
    .clk       (clk),
    .rst_n     (rst_n),
    .load      (res_vld),
    .res       (res),
    .out_stall (out_stall),
    .free      (res_free),
    .out_vld   (out_vld),
    .out_res   (out_res)
  );

  assign out_row_number    = out_res.row_number;
  assign out_column_number = out_res.column_number;
  assign out_field_start   = out_res.field_start;
  assign out_field_length  = out_res.field_length;
  assign out_was_quoted    = out_res.was_quoted;
  assign out_last_of_row   = out_res.last_of_row;
  assign out_end_of_data   = out_res.end_of_data;

endmodule

@@ design/cfs_core.sv @@
// cfs_core: tokenizer state and per-byte update, one byte per cycle unless stalled.
// Depends on cfs_pkg.
module cfs_core (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  byte_vld,
  input  logic [7:0]            byte_data,
  input  logic [7:0]            delimiter_char,
  input  logic [7:0]            quote_char,
  input  logic                  res_free,
  output logic                  proc,
  output logic                  res_vld,
  output cfs_pkg::result_t      res
);

  logic                        in_quotes_r, in_quotes_nxt;
  logic                        quote_seen_r, quote_seen_nxt;
  logic                        pending_cr_r, pending_cr_nxt;
  logic [cfs_pkg::POS_W-1:0]   text_count_r, text_count_nxt;
  logic [cfs_pkg::POS_W-1:0]   start_offset_r, start_offset_nxt;
  logic [cfs_pkg::POS_W-1:0]   row_position_r, row_position_nxt;
  logic [cfs_pkg::COL_W-1:0]   column_r, column_nxt;
  logic [cfs_pkg::ROW_W-1:0]   row_r, row_nxt;

  logic                        crlf, is_q, inq1, qs1, eod, cr, lf, dl, emit;
  logic [cfs_pkg::POS_W-1:0]   tc1, tc_emit, tc_inc, pos_inc;

  always_comb begin
    crlf    = pending_cr_r && (byte_data == cfs_pkg::BYTE_LF);
    tc1     = (pending_cr_r && (text_count_r != cfs_pkg::POS_MAX)) ?
              text_count_r + 1'b1 : text_count_r;
    tc_emit = crlf ? text_count_r : tc1;
    is_q    = !crlf && (byte_data == quote_char);
    inq1    = in_quotes_r ^ is_q;
    qs1     = quote_seen_r | is_q;
    eod     = !crlf && (byte_data == cfs_pkg::BYTE_NUL);
    cr      = !crlf && !eod && !inq1 && (byte_data == cfs_pkg::BYTE_CR);
    lf      = !crlf && !eod && !inq1 && (byte_data == cfs_pkg::BYTE_LF);
    dl      = !crlf && !eod && !inq1 && !cr && !lf && (byte_data == delimiter_char);
    emit    = crlf || lf || eod || dl;
    tc_inc  = (tc1 != cfs_pkg::POS_MAX) ? tc1 + 1'b1 : tc1;
    pos_inc = (row_position_r != cfs_pkg::POS_MAX) ? row_position_r + 1'b1 :
              row_position_r;

    proc    = byte_vld && (res_free || !emit);
    res_vld = proc && emit;

    res.row_number    = row_r;
    res.column_number = column_r;
    res.field_start   = (qs1 && (start_offset_r != cfs_pkg::POS_MAX)) ?
                        start_offset_r + 1'b1 : start_offset_r;
    res.field_length  = !qs1 ? tc_emit :
                        (tc_emit >= cfs_pkg::POS_W'(2)) ? tc_emit - cfs_pkg::POS_W'(2) :
                        '0;
    res.was_quoted    = qs1;
    res.last_of_row   = crlf || lf || eod;
    res.end_of_data   = eod;
  end

  always_comb begin
    in_quotes_nxt    = inq1;
    quote_seen_nxt   = qs1;
    pending_cr_nxt   = 1'b0;
    text_count_nxt   = tc_inc;
    start_offset_nxt = start_offset_r;
    row_position_nxt = pos_inc;
    column_nxt       = column_r;
    row_nxt          = row_r;
    if (crlf || lf) begin
      in_quotes_nxt    = 1'b0;
      quote_seen_nxt   = 1'b0;
      text_count_nxt   = '0;
      start_offset_nxt = '0;
      row_position_nxt = '0;
      column_nxt       = '0;
      row_nxt          = (row_r != cfs_pkg::ROW_MAX) ? row_r + 1'b1 : row_r;
    end else if (eod) begin
      in_quotes_nxt    = 1'b0;
      quote_seen_nxt   = 1'b0;
      text_count_nxt   = '0;
      start_offset_nxt = '0;
      row_position_nxt = '0;
      column_nxt       = '0;
      row_nxt          = '0;
    end else if (cr) begin
      pending_cr_nxt   = 1'b1;
      text_count_nxt   = tc1;
    end else if (dl) begin
      quote_seen_nxt   = 1'b0;
      text_count_nxt   = '0;
      start_offset_nxt = pos_inc;
      column_nxt       = (column_r != cfs_pkg::COL_MAX) ? column_r + 1'b1 : column_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_quotes_r    <= 1'b0;
      quote_seen_r   <= 1'b0;
      pending_cr_r   <= 1'b0;
      text_count_r   <= '0;
      start_offset_r <= '0;
      row_position_r <= '0;
      column_r       <= '0;
      row_r          <= '0;
    end else if (proc) begin
      in_quotes_r    <= in_quotes_nxt;
      quote_seen_r   <= quote_seen_nxt;
      pending_cr_r   <= pending_cr_nxt;
      text_count_r   <= text_count_nxt;
      start_offset_r <= start_offset_nxt;
      row_position_r <= row_position_nxt;
      column_r       <= column_nxt;
      row_r          <= row_nxt;
    end
  end

endmodule

@@ design/cfs_out_reg.sv @@
// cfs_out_reg: result register holding one field until the transfer completes.
// Depends on cfs_pkg.
module cfs_out_reg (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             load,
  input  cfs_pkg::result_t res,
  input  logic             out_stall,
  output logic             free,
  output logic             out_vld,
  output cfs_pkg::result_t out_res
);

  logic             vld_r, vld_nxt;
  cfs_pkg::result_t res_r;

  assign free    = !vld_r || !out_stall;
  assign vld_nxt = load || (vld_r && out_stall);
  assign out_vld = vld_r;
  assign out_res = res_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      res_r <= res;
    end
  end

endmodule

@@ design/cfs_checker.sv @@
// cfs_checker: port-level assertions for csv_field_splitter_unit, with bind.
// Depends on the top level's ports only.
module cfs_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        out_vld,
  input logic        out_stall,
  input logic [15:0] out_row_number,
  input logic [7:0]  out_column_number,
  input logic [11:0] out_field_start,
  input logic [11:0] out_field_length,
  input logic        out_was_quoted,
  input logic        out_last_of_row,
  input logic        out_end_of_data
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_vld && out_stall |=> out_vld && $stable(out_row_number) &&
      $stable(out_column_number) && $stable(out_field_start) &&
      $stable(out_field_length) && $stable(out_was_quoted) &&
      $stable(out_last_of_row) && $stable(out_end_of_data))
    else $error("stalled result changed");

  a_reset_idle: assert property (@(posedge clk)
    !$past(rst_n) |-> !out_vld)
    else $error("result valid right after reset");

  a_eod_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_vld && out_end_of_data |-> out_last_of_row)
    else $error("end of data without end of row");

  a_quoted_start: assert property (@(posedge clk) disable iff (!rst_n)
    out_vld && out_was_quoted |-> out_field_start != 12'd0)
    else $error("quoted field starts at zero");

endmodule

bind csv_field_splitter_unit cfs_checker u_cfs_checker (
  .clk               (clk),
  .rst_n             (rst_n),
  .out_vld           (out_vld),
  .out_stall         (out_stall),
  .out_row_number    (out_row_number),
  .out_column_number (out_column_number),
  .out_field_start   (out_field_start),
  .out_field_length  (out_field_length),
  .out_was_quoted    (out_was_quoted),
  .out_last_of_row   (out_last_of_row),
  .out_end_of_data   (out_end_of_data)
);
